// File: hdl/c2r_pkg.sv
// ----------------------------------------------------------------------------
// c2r_pkg: shared types and constants of the 3x3 replicate-border filter
// Pixel and column types, control bundle, register codes and reset values.
// ----------------------------------------------------------------------------
package c2r_pkg;

    localparam int PIX_W      = 8;
    localparam int GEOM_W     = 11;
    localparam int COEF_W     = 16;
    localparam int KROW_W     = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam int PROD_W = COEF_W + PIX_W + 1;
    localparam int RSUM_W = PROD_W + 2;
    localparam int SUM_W  = RSUM_W + 2;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int RST_IMAGE_WIDTH  = 1024;
    localparam int RST_IMAGE_HEIGHT = 1024;
    localparam logic [KROW_W-1:0] RST_KROW_OUTER = 48'hFF00_0000_0100;
    localparam logic [KROW_W-1:0] RST_KROW_MID   = 48'hFE00_0000_0200;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KROW_TOP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KROW_MID     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KROW_BOT     = 3'd4;

    typedef logic [PIX_W-1:0] t_pixel;

    typedef struct packed {
        t_pixel top;
        t_pixel mid;
        t_pixel bot;
    } t_column;

    typedef struct packed {
        logic emit;
        logic tclamp;
        logic bclamp;
        logic lclamp;
        logic rclamp;
        logic last;
    } t_ctl;

    // replicate the middle row over a missing top or bottom row
    function automatic t_column clamp_rows(t_column col, logic tcl, logic bcl);
        t_column res;
        res     = col;
        res.top = tcl ? col.mid : col.top;
        res.bot = bcl ? col.mid : col.bot;
        return res;
    endfunction

endpackage

// File: hdl/c2r_line_delay.sv
// ----------------------------------------------------------------------------
// c2r_line_delay: one-line pixel delay
// Read-before-write memory addressed by column; returns the word stored at
// the same column one row earlier.
// ----------------------------------------------------------------------------
module c2r_line_delay #(
    parameter int DEPTH = c2r_pkg::DEF_MAX_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  c2r_pkg::t_pixel          i_data,
    output c2r_pkg::t_pixel          o_data
);

    c2r_pkg::t_pixel r_mem [DEPTH];
    c2r_pkg::t_pixel r_rd;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd           <= r_mem[i_addr];
            r_mem[i_addr]  <= i_data;
        end
    end

    assign o_data = r_rd;

endmodule

// File: hdl/c2r_col_cell.sv
// ----------------------------------------------------------------------------
// c2r_col_cell: one column of the 3x3 window
// Holds three vertically adjacent pixels and passes them to the next cell
// on every shift.
// ----------------------------------------------------------------------------
module c2r_col_cell (
    input  logic             i_clk,
    input  logic             i_shift,
    input  c2r_pkg::t_column i_col,
    output c2r_pkg::t_column o_col
);

    c2r_pkg::t_column r_col;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

endmodule

// File: hdl/conv2d_3x3_replicate_border_top.sv
// ----------------------------------------------------------------------------
// conv2d_3x3_replicate_border_top: streaming 3x3 filter, replicated border
// Raster pixels in, Q8.8 kernel, round half to even, clamp to 0..255.
//
//   channel  direction  handshake                 payload
//   in       in         i_in_valid / o_in_stall   i_mode, i_pixel
//   out      out        o_out_valid / i_out_stall o_result_pixel, o_last_of_frame
//   cfg      in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One word accepted per cycle while o_in_stall is low; a result leaves through the
// stage registers after the word that releases it (W+1 words after its centre pixel).
// Line history sits in two single-port memories, one access per word each.
// Reset clears counters and valids and reloads the configuration defaults; no memory clearing pass.
// Stall from the output ripples back through the stage ready chain; empty
// stages still fill while the output word waits.
// ----------------------------------------------------------------------------
module conv2d_3x3_replicate_border_top #(
    parameter int MAX_WIDTH  = c2r_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = c2r_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_mode,
    input  logic [c2r_pkg::PIX_W-1:0]        i_pixel,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [c2r_pkg::PIX_W-1:0]        o_result_pixel,
    output logic                             o_last_of_frame,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [c2r_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [c2r_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int WCW = $clog2(MAX_WIDTH + 1);
    localparam int HCW = $clog2(MAX_HEIGHT + 1);
    localparam int ICW = $clog2(MAX_WIDTH);
    localparam int IRW = $clog2(MAX_HEIGHT + 2);
    localparam int ORW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int W_RST = (MAX_WIDTH < c2r_pkg::RST_IMAGE_WIDTH) ?
                           MAX_WIDTH : c2r_pkg::RST_IMAGE_WIDTH;
    localparam int H_RST = (MAX_HEIGHT < c2r_pkg::RST_IMAGE_HEIGHT) ?
                           MAX_HEIGHT : c2r_pkg::RST_IMAGE_HEIGHT;
    localparam int PW  = c2r_pkg::PROD_W;
    localparam int RSW = c2r_pkg::RSUM_W;
    localparam int SW  = c2r_pkg::SUM_W;
    localparam int CW  = c2r_pkg::COEF_W;

    // configuration
    logic [WCW-1:0]              r_w;
    logic [HCW-1:0]              r_h;
    logic [c2r_pkg::KROW_W-1:0]  r_krow [3];
    logic                        cfg_wr;
    logic                        geom_wr;
    logic [c2r_pkg::GEOM_W-1:0]  cfg_geom;

    // position counters
    logic [ICW-1:0] r_icol;
    logic [IRW-1:0] r_irow;
    logic [ICW-1:0] r_ocol;
    logic [ORW-1:0] r_orow;

    // stage 0
    logic          in_frame;
    logic          acc;
    logic          ins;
    logic          icol_end;
    logic          ocol_end;
    c2r_pkg::t_ctl ctl0;

    // pipeline
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;

    c2r_pkg::t_pixel  r_pix1;
    logic [ICW-1:0]   r_addr1;
    c2r_pkg::t_ctl    r_ctl1;
    c2r_pkg::t_pixel  mid1;

    c2r_pkg::t_pixel  r_pix2;
    c2r_pkg::t_pixel  r_mid2;
    c2r_pkg::t_ctl    r_ctl2;
    c2r_pkg::t_pixel  top2;

    logic             win_shift;
    c2r_pkg::t_column col_in;
    c2r_pkg::t_column cell0, cell1, cell2;
    c2r_pkg::t_ctl    r_ctl3;

    c2r_pkg::t_column col_sel [3];
    c2r_pkg::t_pixel  win [3][3];
    logic signed [PW-1:0]  n_prod [3][3];
    logic signed [PW-1:0]  r_prod [3][3];
    logic                  r_last4;

    logic signed [RSW-1:0] r_rsum [3];
    logic                  r_last5;
    logic signed [SW-1:0]  r_sum;
    logic                  r_last6;

    logic [7:0]            frac;
    logic                  rnd_inc;
    logic signed [SW-8:0]  q;
    logic [c2r_pkg::PIX_W-1:0] n_res;
    logic [c2r_pkg::PIX_W-1:0] r_res;
    logic                      r_last7;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;
    assign cfg_wr   = i_cfg_valid && o_cfg_ready;
    assign geom_wr  = cfg_wr && (i_cfg_index == c2r_pkg::CFG_IMAGE_WIDTH ||
                                 i_cfg_index == c2r_pkg::CFG_IMAGE_HEIGHT);
    assign cfg_geom = i_cfg_data[c2r_pkg::GEOM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w       <= WCW'(W_RST);
            r_h       <= HCW'(H_RST);
            r_krow[0] <= c2r_pkg::RST_KROW_OUTER;
            r_krow[1] <= c2r_pkg::RST_KROW_MID;
            r_krow[2] <= c2r_pkg::RST_KROW_OUTER;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                c2r_pkg::CFG_IMAGE_WIDTH: begin
                    if (cfg_geom == '0) begin
                        r_w <= WCW'(1);
                    end else if (32'(cfg_geom) > MAX_WIDTH) begin
                        r_w <= WCW'(MAX_WIDTH);
                    end else begin
                        r_w <= WCW'(cfg_geom);
                    end
                end
                c2r_pkg::CFG_IMAGE_HEIGHT: begin
                    if (cfg_geom == '0) begin
                        r_h <= HCW'(1);
                    end else if (32'(cfg_geom) > MAX_HEIGHT) begin
                        r_h <= HCW'(MAX_HEIGHT);
                    end else begin
                        r_h <= HCW'(cfg_geom);
                    end
                end
                c2r_pkg::CFG_KROW_TOP: r_krow[0] <= i_cfg_data[c2r_pkg::KROW_W-1:0];
                c2r_pkg::CFG_KROW_MID: r_krow[1] <= i_cfg_data[c2r_pkg::KROW_W-1:0];
                c2r_pkg::CFG_KROW_BOT: r_krow[2] <= i_cfg_data[c2r_pkg::KROW_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- ready chain ----------------
    assign rdy7 = !r_v7 || !i_out_stall;
    assign rdy6 = !r_v6 || rdy7;
    assign rdy5 = !r_v5 || rdy6;
    assign rdy4 = !r_v4 || rdy5;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign o_in_stall = !rdy1;

    // ---------------- stage 0: positions ----------------
    always_comb begin
        in_frame    = r_irow < IRW'(r_h);
        acc         = i_in_valid && rdy1;
        // drain tick inside the frame is dropped
        ins         = acc && !(in_frame && i_mode);
        icol_end    = WCW'(r_icol) == r_w - WCW'(1);
        ocol_end    = WCW'(r_ocol) == r_w - WCW'(1);
        ctl0.emit   = (r_irow > IRW'(1)) || (r_irow == IRW'(1) && r_icol != '0);
        ctl0.tclamp = r_orow == '0;
        ctl0.bclamp = HCW'(r_orow) == r_h - HCW'(1);
        ctl0.lclamp = r_ocol == '0;
        ctl0.rclamp = ocol_end;
        ctl0.last   = ctl0.bclamp && ocol_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || geom_wr) begin
            r_icol <= '0;
            r_irow <= '0;
            r_ocol <= '0;
            r_orow <= '0;
        end else if (ins) begin
            if (ctl0.emit && ctl0.last) begin
                r_icol <= '0;
                r_irow <= '0;
                r_ocol <= '0;
                r_orow <= '0;
            end else begin
                if (icol_end) begin
                    r_icol <= '0;
                    r_irow <= r_irow + IRW'(1);
                end else begin
                    r_icol <= r_icol + ICW'(1);
                end
                if (ctl0.emit) begin
                    if (ocol_end) begin
                        r_ocol <= '0;
                        r_orow <= r_orow + ORW'(1);
                    end else begin
                        r_ocol <= r_ocol + ICW'(1);
                    end
                end
            end
        end
    end

    // ---------------- valids ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= ins;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2 && r_ctl2.emit;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
            if (rdy6) r_v6 <= r_v5;
            if (rdy7) r_v7 <= r_v6;
        end
    end

    // ---------------- stage 1: first line delay ----------------
    c2r_line_delay #(
        .DEPTH (MAX_WIDTH)
    ) u_ld_mid (
        .i_clk  (i_clk),
        .i_en   (ins),
        .i_addr (r_icol),
        .i_data (i_pixel),
        .o_data (mid1)
    );

    always_ff @(posedge i_clk) begin
        if (ins) begin
            r_pix1  <= i_pixel;
            r_addr1 <= r_icol;
            r_ctl1  <= ctl0;
        end
    end

    // ---------------- stage 2: second line delay ----------------
    c2r_line_delay #(
        .DEPTH (MAX_WIDTH)
    ) u_ld_top (
        .i_clk  (i_clk),
        .i_en   (rdy2 && r_v1),
        .i_addr (r_addr1),
        .i_data (mid1),
        .o_data (top2)
    );

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            r_pix2 <= r_pix1;
            r_mid2 <= mid1;
            r_ctl2 <= r_ctl1;
        end
    end

    // ---------------- stage 3: window cells ----------------
    assign win_shift  = rdy3 && r_v2;
    assign col_in.top = top2;
    assign col_in.mid = r_mid2;
    assign col_in.bot = r_pix2;

    c2r_col_cell u_cell0 (
        .i_clk   (i_clk),
        .i_shift (win_shift),
        .i_col   (col_in),
        .o_col   (cell0)
    );

    c2r_col_cell u_cell1 (
        .i_clk   (i_clk),
        .i_shift (win_shift),
        .i_col   (cell0),
        .o_col   (cell1)
    );

    c2r_col_cell u_cell2 (
        .i_clk   (i_clk),
        .i_shift (win_shift),
        .i_col   (cell1),
        .o_col   (cell2)
    );

    always_ff @(posedge i_clk) begin
        if (win_shift) begin
            r_ctl3 <= r_ctl2;
        end
    end

    // ---------------- stage 4: border select and products ----------------
    always_comb begin
        col_sel[0] = c2r_pkg::clamp_rows(r_ctl3.lclamp ? cell1 : cell2,
                                         r_ctl3.tclamp, r_ctl3.bclamp);
        col_sel[1] = c2r_pkg::clamp_rows(cell1, r_ctl3.tclamp, r_ctl3.bclamp);
        col_sel[2] = c2r_pkg::clamp_rows(r_ctl3.rclamp ? cell1 : cell0,
                                         r_ctl3.tclamp, r_ctl3.bclamp);
        for (int j = 0; j < 3; j++) begin
            win[0][j] = col_sel[j].top;
            win[1][j] = col_sel[j].mid;
            win[2][j] = col_sel[j].bot;
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_prod[i][j] = $signed(r_krow[i][CW*j +: CW]) * $signed({1'b0, win[i][j]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4 && r_v3) begin
            r_prod  <= n_prod;
            r_last4 <= r_ctl3.last;
        end
    end

    // ---------------- stage 5/6: sums ----------------
    always_ff @(posedge i_clk) begin
        if (rdy5 && r_v4) begin
            for (int i = 0; i < 3; i++) begin
                r_rsum[i] <= RSW'(r_prod[i][0]) + RSW'(r_prod[i][1]) + RSW'(r_prod[i][2]);
            end
            r_last5 <= r_last4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy6 && r_v5) begin
            r_sum   <= SW'(r_rsum[0]) + SW'(r_rsum[1]) + SW'(r_rsum[2]);
            r_last6 <= r_last5;
        end
    end

    // ---------------- stage 7: round half to even, clamp ----------------
    always_comb begin
        frac    = r_sum[7:0];
        rnd_inc = (frac > 8'd128) || (frac == 8'd128 && r_sum[8]);
        q       = $signed({r_sum[SW-1], r_sum[SW-1:8]}) + $signed({{(SW-8){1'b0}}, rnd_inc});
        if (q[SW-8]) begin
            n_res = '0;
        end else if (q > $signed((SW-7)'(255))) begin
            n_res = '1;
        end else begin
            n_res = q[c2r_pkg::PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy7 && r_v6) begin
            r_res   <= n_res;
            r_last7 <= r_last6;
        end
    end

    assign o_out_valid     = r_v7;
    assign o_result_pixel  = r_res;
    assign o_last_of_frame = r_last7;

    // ---------------- assertions ----------------
    a_irow_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_irow <= IRW'(r_h) + IRW'(1))
        else $error("input row past frame plus drain");

    a_orow_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        HCW'(r_orow) < r_h)
        else $error("output row outside frame");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ins && ctl0.emit && ctl0.last) |=>
        (r_icol == '0 && r_irow == '0 && r_ocol == '0 && r_orow == '0))
        else $error("counters not restarted after last pixel of frame");

endmodule
